/* src/i2c_master_bit_sequencer_core_defines.svh */
// Assertion macros for the I2C master bit sequencer checker.
// Depends on nothing; the including scope provides clk and rst_n.
`ifndef I2C_MASTER_BIT_SEQUENCER_CORE_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_CORE_DEFINES_SVH

// Consequent must hold on the same edge as the antecedent.
`define I2CMS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold on the edge after the antecedent.
`define I2CMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/i2cms_pkg.sv */
// Shared types and codes for the I2C master bit sequencer.
// No dependencies; imported by every module of the block.
package i2cms_pkg;

  localparam int CFG_IDX_W = 3;

  // Timing register indexes on the cfg_ port.
  localparam logic [CFG_IDX_W-1:0] REG_START = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STOP  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SETUP = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_LOW   = CFG_IDX_W'(4);

  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_ADDR  = 3'd2;
  localparam logic [2:0] ACT_WRITE = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;
  localparam logic [2:0] ACT_STOP  = 3'd5;

  typedef struct packed {
    logic [2:0] action;
    logic [6:0] device_address;
    logic       read_not_write;
    logic [7:0] data_byte;
    logic       send_nack;
    logic       sda_in;
  } i2cms_in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       cmd_taken;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack;
    logic       aborted;
  } i2cms_out_t;

  // Classified tick as held in the queue between front and engine.
  typedef struct packed {
    logic       is_cmd;
    logic [2:0] op;
    logic [7:0] load_byte;
    logic       ack_bit;
    logic       sda_in;
  } i2cms_item_t;

  typedef struct packed {
    logic        valid;
    i2cms_item_t item;
  } i2cms_head_t;

endpackage

/* src/i2cms_front.sv */
// Front end: accepts ticks, decodes the command and queues the result.
// Depends on i2cms_pkg.
module i2cms_front import i2cms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  i2cms_in_t   in_data,
  output i2cms_head_t head,
  input  logic        head_pop
);

  i2cms_item_t q_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  logic        pop;
  i2cms_item_t item;

  always_comb begin
    item.is_cmd    = in_data.action inside {[ACT_START:ACT_STOP]};
    item.op        = in_data.action;
    item.ack_bit   = in_data.send_nack;
    item.sda_in    = in_data.sda_in;
    case (in_data.action)
      ACT_ADDR:  item.load_byte = {in_data.device_address, in_data.read_not_write};
      ACT_WRITE: item.load_byte = in_data.data_byte;
      default:   item.load_byte = 8'd0;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = head_pop && (cnt_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rd_ptr_r];

endmodule

/* src/i2cms_engine.sv */
// Back end: pin sequencer that carries out queued ticks, plus timing registers
// and the result register. Depends on i2cms_pkg.
module i2cms_engine import i2cms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  i2cms_head_t          head,
  output logic                 head_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cms_out_t           out_data
);

  typedef enum logic [13:0] {
    PH_IDLE   = 14'h0001,
    PH_ST0    = 14'h0002,
    PH_ST1    = 14'h0004,
    PH_ST2    = 14'h0008,
    PH_ST3    = 14'h0010,
    PH_SP0    = 14'h0020,
    PH_SP1    = 14'h0040,
    PH_SP2    = 14'h0080,
    PH_SP3    = 14'h0100,
    PH_TXSET  = 14'h0200,
    PH_TXHIGH = 14'h0400,
    PH_TXLOW  = 14'h0800,
    PH_RXHIGH = 14'h1000,
    PH_RXLOW  = 14'h2000
  } phase_t;

  logic [7:0] start_ticks_r, stop_ticks_r, setup_ticks_r, high_ticks_r, low_ticks_r;

  phase_t     phase_r, phase_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       op_read_r, op_read_nxt;
  logic       nack_r, nack_nxt;
  logic       abort_r, abort_nxt;
  logic       ack_r, ack_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       drv_r, drv_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic       taken_r, taken_nxt;
  logic       done_r, done_nxt;
  logic       settle_r, settle_nxt;
  logic       out_valid_r, out_valid_nxt;
  i2cms_out_t out_data_r, out_data_nxt;

  logic       step_en;
  logic       more;
  logic       do_adv;
  logic       do_ent;
  logic       do_fin;
  phase_t     ent;
  logic [7:0] wait_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_ticks_r <= 8'd6;
      stop_ticks_r  <= 8'd6;
      setup_ticks_r <= 8'd1;
      high_ticks_r  <= 8'd9;
      low_ticks_r   <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START: start_ticks_r <= cfg_wdata;
        REG_STOP:  stop_ticks_r  <= cfg_wdata;
        REG_SETUP: setup_ticks_r <= cfg_wdata;
        REG_HIGH:  high_ticks_r  <= cfg_wdata;
        REG_LOW:   low_ticks_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // One pin step per cycle unless stalled: either the tick's own step (command or
  // countdown) or, while settling, one more step that a zero hold let through.
  always_comb begin
    step_en     = head.valid && (!out_valid_r || out_ready);
    phase_nxt   = phase_r;
    wait_nxt    = wait_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    op_read_nxt = op_read_r;
    nack_nxt    = nack_r;
    abort_nxt   = abort_r;
    ack_nxt     = ack_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    drv_nxt     = drv_r;
    rx_nxt      = rx_r;
    taken_nxt   = settle_r ? taken_r : 1'b0;
    done_nxt    = settle_r ? done_r : 1'b0;
    do_adv      = 1'b0;
    do_ent      = 1'b0;
    do_fin      = 1'b0;
    ent         = PH_IDLE;
    wait_dec    = wait_r;

    if (!settle_r) begin
      if (phase_r == PH_IDLE) begin
        if (head.item.is_cmd) begin
          taken_nxt   = 1'b1;
          op_read_nxt = (head.item.op == ACT_READ);
          nack_nxt    = 1'b0;
          abort_nxt   = 1'b0;
          bit_nxt     = 4'd0;
          do_ent      = 1'b1;
          case (head.item.op)
            ACT_START: ent = PH_ST0;
            ACT_ADDR, ACT_WRITE: begin
              shift_nxt = head.item.load_byte;
              ent       = PH_TXSET;
            end
            ACT_READ: begin
              shift_nxt = 8'd0;
              ack_nxt   = head.item.ack_bit;
              ent       = PH_RXHIGH;
            end
            default: ent = PH_SP0;
          endcase
        end
      end else begin
        if (wait_r != 8'd0) begin
          wait_dec = wait_r - 8'd1;
        end
        wait_nxt = wait_dec;
        do_adv   = (wait_dec == 8'd0);
      end
    end else begin
      do_adv = 1'b1;
    end

    if (do_adv) begin
      case (phase_r)
        PH_ST0:    begin do_ent = 1'b1; ent = PH_ST1;    end
        PH_ST1:    begin do_ent = 1'b1; ent = PH_ST2;    end
        PH_ST2:    begin do_ent = 1'b1; ent = PH_ST3;    end
        PH_SP0:    begin do_ent = 1'b1; ent = PH_SP1;    end
        PH_SP1:    begin do_ent = 1'b1; ent = PH_SP2;    end
        PH_SP2:    begin do_ent = 1'b1; ent = PH_SP3;    end
        PH_TXSET:  begin do_ent = 1'b1; ent = PH_TXHIGH; end
        PH_TXHIGH: begin do_ent = 1'b1; ent = PH_TXLOW;  end
        PH_RXHIGH: begin do_ent = 1'b1; ent = PH_RXLOW;  end
        PH_TXLOW: begin
          if (op_read_r) begin
            do_fin = 1'b1;
          end else begin
            shift_nxt = {shift_r[6:0], 1'b0};
            bit_nxt   = bit_r + 4'd1;
            do_ent    = 1'b1;
            ent       = (bit_nxt < 4'd8) ? PH_TXSET : PH_RXHIGH;
          end
        end
        PH_RXLOW: begin
          if (op_read_r) begin
            bit_nxt = bit_r + 4'd1;
            do_ent  = 1'b1;
            ent     = (bit_nxt < 4'd8) ? PH_RXHIGH : PH_TXSET;
          end else if (nack_r) begin
            abort_nxt = 1'b1;
            do_ent    = 1'b1;
            ent       = PH_SP0;
          end else begin
            do_fin = 1'b1;
          end
        end
        default: do_fin = 1'b1;
      endcase
    end

    if (do_ent) begin
      phase_nxt = ent;
      case (ent)
        PH_ST0:    begin drv_nxt = 1'b1; sda_nxt = 1'b1; wait_nxt = start_ticks_r; end
        PH_ST1:    begin scl_nxt = 1'b1; wait_nxt = start_ticks_r; end
        PH_ST2:    begin drv_nxt = 1'b1; sda_nxt = 1'b0; wait_nxt = start_ticks_r; end
        PH_ST3:    begin scl_nxt = 1'b0; wait_nxt = start_ticks_r; end
        PH_SP0:    begin scl_nxt = 1'b0; wait_nxt = stop_ticks_r; end
        PH_SP1:    begin drv_nxt = 1'b1; sda_nxt = 1'b0; wait_nxt = stop_ticks_r; end
        PH_SP2:    begin scl_nxt = 1'b1; wait_nxt = stop_ticks_r; end
        PH_SP3:    begin drv_nxt = 1'b1; sda_nxt = 1'b1; do_fin = 1'b1; end
        PH_TXSET: begin
          drv_nxt  = 1'b1;
          sda_nxt  = op_read_nxt ? ack_nxt : shift_nxt[7];
          wait_nxt = setup_ticks_r;
        end
        PH_TXHIGH: begin scl_nxt = 1'b1; wait_nxt = high_ticks_r; end
        PH_TXLOW:  begin scl_nxt = 1'b0; wait_nxt = low_ticks_r;  end
        PH_RXHIGH: begin
          drv_nxt  = 1'b0;
          sda_nxt  = 1'b1;
          scl_nxt  = 1'b1;
          wait_nxt = high_ticks_r;
        end
        PH_RXLOW: begin
          // Data or acknowledge bit is sampled as SCL falls.
          if (op_read_nxt) begin
            shift_nxt = {shift_nxt[6:0], head.item.sda_in};
          end else begin
            nack_nxt = head.item.sda_in;
          end
          scl_nxt  = 1'b0;
          wait_nxt = low_ticks_r;
        end
        default: do_fin = 1'b1;
      endcase
    end

    if (do_fin) begin
      if (op_read_nxt && !abort_nxt) begin
        rx_nxt = shift_nxt;
      end
      phase_nxt = PH_IDLE;
      wait_nxt  = 8'd0;
      done_nxt  = 1'b1;
    end

    more       = (phase_nxt != PH_IDLE) && (wait_nxt == 8'd0);
    head_pop   = step_en && !more;
    settle_nxt = step_en ? more : settle_r;

    out_data_nxt.scl_out   = scl_nxt;
    out_data_nxt.sda_out   = drv_nxt ? sda_nxt : 1'b1;
    out_data_nxt.sda_drive = drv_nxt;
    out_data_nxt.busy_res  = (phase_nxt != PH_IDLE);
    out_data_nxt.cmd_taken = taken_nxt;
    out_data_nxt.done_res  = done_nxt;
    out_data_nxt.rx_byte   = rx_nxt;
    out_data_nxt.nack      = nack_nxt;
    out_data_nxt.aborted   = abort_nxt;

    if (head_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      wait_r      <= 8'd0;
      bit_r       <= 4'd0;
      shift_r     <= 8'd0;
      op_read_r   <= 1'b0;
      nack_r      <= 1'b0;
      abort_r     <= 1'b0;
      ack_r       <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      drv_r       <= 1'b1;
      rx_r        <= 8'd0;
      taken_r     <= 1'b0;
      done_r      <= 1'b0;
      settle_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (step_en) begin
        phase_r   <= phase_nxt;
        wait_r    <= wait_nxt;
        bit_r     <= bit_nxt;
        shift_r   <= shift_nxt;
        op_read_r <= op_read_nxt;
        nack_r    <= nack_nxt;
        abort_r   <= abort_nxt;
        ack_r     <= ack_nxt;
        scl_r     <= scl_nxt;
        sda_r     <= sda_nxt;
        drv_r     <= drv_nxt;
        rx_r      <= rx_nxt;
        taken_r   <= taken_nxt;
        done_r    <= done_nxt;
      end
      settle_r    <= settle_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/i2c_master_bit_sequencer_core.sv */
// I2C master bit sequencer. Each accepted input transfer is one timing tick
// with the sampled SDA level and an optional command; each produces exactly one
// result transfer with the SCL/SDA pin levels and status after that tick. A
// two-entry queue sits between the command decoder and the pin sequencer, and
// a result register sits at the output, so a tick is accepted every cycle
// while the result side keeps up and no tick takes extra steps; the result
// of a tick passes through the queue and the result register. The sequencer
// makes one pin step per cycle while not stalled; a tick on which steps with
// a zero hold count follow each other also takes each such further step
// before its result is offered, up to a whole byte that ends in an automatic
// stop. Timing registers are written through the cfg_ port, index 0 start,
// 1 stop, 2 setup, 3 high, 4 low.
// Depends on i2cms_pkg, i2cms_front and i2cms_engine.
module i2c_master_bit_sequencer_core import i2cms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cms_in_t            in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cms_out_t           out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  i2cms_head_t head;
  logic        head_pop;

  i2cms_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .head     (head),
    .head_pop (head_pop)
  );

  i2cms_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .head_pop  (head_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* src/i2cms_checker.sv */
// Port-level checker for the I2C master bit sequencer, bound to the top level.
// Depends on i2cms_pkg and i2c_master_bit_sequencer_core_defines.svh.
`include "i2c_master_bit_sequencer_core_defines.svh"

module i2cms_checker import i2cms_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input i2cms_out_t out_data
);

  // A stalled result transfer must stay offered unchanged.
  `I2CMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // A taken command either leaves an operation running or finished it at once.
  `I2CMS_ASSERT_SAME(a_taken_active, out_valid && out_data.cmd_taken, out_data.busy_res || out_data.done_res, "command taken without activity")

  // Finishing an operation always returns the sequencer to idle.
  `I2CMS_ASSERT_SAME(a_done_idle, out_valid && out_data.done_res, !out_data.busy_res, "done while still busy")

  // An automatic stop is only issued after a NACK.
  `I2CMS_ASSERT_SAME(a_abort_nack, out_valid && out_data.aborted, out_data.nack, "abort without nack")

endmodule

bind i2c_master_bit_sequencer_core i2cms_checker u_i2cms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
